/* rtl/sgs_pkg.sv */
`default_nettype none

package sgs_pkg;

	localparam int DATA_W    = 32;
	localparam int ACC_W     = 64;
	localparam int RES_W     = 31;
	localparam int IDX_W     = 8;
	localparam int ROWCNT_W  = 9;
	localparam int LIMIT_W   = 8;
	localparam int CMD_W     = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [CMD_W-1:0] CMD_LOAD_ENTRY  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_VECTOR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SOLVE       = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ        = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_LIMIT = 2'd2;

	localparam logic [ROWCNT_W-1:0] ROW_COUNT_RST   = 9'd256;
	localparam logic [RES_W-1:0]    TOLERANCE_RST   = 31'd66;
	localparam logic [LIMIT_W-1:0]  SWEEP_LIMIT_RST = 8'd100;

	localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [RES_W-1:0]         RES_MAX  = {RES_W{1'b1}};

	typedef enum logic [4:0] {
		S_IDLE,
		S_LOAD_FILL,
		S_READ,
		S_ROW_A,
		S_ROW_B,
		S_ROW_C,
		S_ROW_D,
		S_ENT_A,
		S_ENT_B,
		S_ENT_C,
		S_ENT_D,
		S_OLD_A,
		S_OLD_B,
		S_DIV,
		S_WB,
		S_SWEEP_END
	} state_t;

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_LAST,
		PH_EVEN,
		PH_ODD
	} phase_t;

endpackage

`default_nettype wire

/* rtl/sgs_divider.sv */
`default_nettype none

module sgs_divider (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [sgs_pkg::ACC_W-1:0]   dividend,
	input  wire logic [sgs_pkg::DATA_W-1:0]  divisor,
	output logic                             done,
	output logic [sgs_pkg::ACC_W-1:0]        quotient
);
	import sgs_pkg::*;

	localparam int CW = $clog2(ACC_W);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [ACC_W-1:0]  num_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] den_q;
	logic [DATA_W:0]   rem_sh;
	logic [DATA_W:0]   rem_sub;
	logic              take;

	always_comb begin
		rem_sh  = {rem_q, num_q[ACC_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		take    = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(ACC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[ACC_W-2:0], take};
			rem_q <= take ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

`default_nettype wire

/* rtl/sparse_gauss_seidel_solver_unit.sv */
// Sparse Gauss-Seidel solver in signed fixed point. Matrix entries are loaded row by row
// with the diagonal first, then right-hand side and guess, then a solve word runs sweeps
// (row 0, last row, even rows, odd rows) until the largest change of a sweep drops below
// the tolerance or the sweep limit is reached, and returns one result word. A load that
// opens a row past the next one also fills the row start of each skipped row in
// S_LOAD_FILL. A solution read passes through S_READ before its result word is offered.
// Each sweep makes n+2 row updates for even n and n+1 for odd n. An update reads the
// solution value of each off-diagonal entry (entries whose column is out of range are
// skipped) and its old value through the single read port of the solution store, and,
// unless the diagonal is zero, waits on the 64-bit restoring divider, which makes one
// quotient bit per cycle. The stores are not cleared: reading a solution or right-hand
// side element that was never written gives an undefined result.
`default_nettype none

module sparse_gauss_seidel_solver_unit #(
	parameter int MAX_ROWS     = 256,
	parameter int MAX_NONZEROS = 2048,
	parameter int FRAC_BITS    = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [sgs_pkg::CMD_W-1:0]           cmd,
	input  wire logic [sgs_pkg::IDX_W-1:0]           row_index,
	input  wire logic [sgs_pkg::IDX_W-1:0]           col_index,
	input  wire logic signed [sgs_pkg::DATA_W-1:0]   entry_value,
	input  wire logic signed [sgs_pkg::DATA_W-1:0]   rhs_value,
	input  wire logic signed [sgs_pkg::DATA_W-1:0]   guess_value,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     result_kind,
	output logic [sgs_pkg::LIMIT_W-1:0]              sweep_index,
	output logic [sgs_pkg::RES_W-1:0]                final_residual,
	output logic signed [sgs_pkg::DATA_W-1:0]        solution_value,
	output logic                                     divide_fault,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [sgs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [sgs_pkg::RES_W-1:0]           cfg_data
);
	import sgs_pkg::*;

	localparam int RW = $clog2(MAX_ROWS);
	localparam int SW = $clog2(MAX_ROWS + 1);
	localparam int EW = $clog2(MAX_NONZEROS);
	localparam int FW = $clog2(MAX_NONZEROS + 1);
	localparam int KW = FW + 1;

	// Stores.
	logic signed [DATA_W-1:0] sol_mem  [MAX_ROWS];
	logic signed [DATA_W-1:0] rhs_mem  [MAX_ROWS];
	logic signed [DATA_W-1:0] coef_mem [MAX_NONZEROS];
	logic [IDX_W-1:0]         col_mem  [MAX_NONZEROS];
	logic [FW-1:0]            rs_mem   [MAX_ROWS+1];

	logic                     sol_we;
	logic [RW-1:0]            sol_waddr;
	logic signed [DATA_W-1:0] sol_wdata;
	logic [RW-1:0]            sol_raddr;
	logic signed [DATA_W-1:0] sol_rd;
	logic                     rhs_we;
	logic [RW-1:0]            rhs_raddr;
	logic signed [DATA_W-1:0] rhs_rd;
	logic                     coef_we;
	logic [EW-1:0]            coef_raddr;
	logic signed [DATA_W-1:0] coef_rd;
	logic [IDX_W-1:0]         col_rd;
	logic                     rs_we;
	logic [SW-1:0]            rs_waddr;
	logic [FW-1:0]            rs_wdata;
	logic [SW-1:0]            rs_raddr;
	logic [FW-1:0]            rs_rd;

	// Control registers.
	state_t                state_q, state_d;
	logic [ROWCNT_W-1:0]   row_count_q;
	logic [RES_W-1:0]      tolerance_q;
	logic [LIMIT_W-1:0]    sweep_limit_q;
	logic [FW-1:0]         fill_q;
	logic                  open_q;
	logic                  any_q;
	logic [RW-1:0]         last_q;
	logic                  fault_q;
	logic                  out_valid_q;

	// Datapath registers.
	logic [SW-1:0]            n_q;
	logic [LIMIT_W-1:0]       it_q;
	logic [DATA_W-1:0]        res_q;
	phase_t                   phase_q;
	logic [RW-1:0]            j_q;
	logic [SW-1:0]            fq_q;
	logic [SW-1:0]            ftgt_q;
	logic [FW-1:0]            fval_q;
	logic                     rd_ok_q;
	logic [FW-1:0]            start_q;
	logic [FW-1:0]            end_q;
	logic [KW-1:0]            k_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [DATA_W-1:0] diag_q;
	logic signed [DATA_W-1:0] coef_q;
	logic signed [ACC_W-1:0]  prod_q;
	logic signed [DATA_W-1:0] old_q;
	logic signed [DATA_W-1:0] nv_q;
	logic                     neg_q;
	logic                     kind_q;
	logic [LIMIT_W-1:0]       sweep_q;
	logic [RES_W-1:0]         resid_q;
	logic signed [DATA_W-1:0] solv_q;
	logic                     ofault_q;

	// Combinational helpers.
	logic                     accept;
	logic [31:0]              in_row32;
	logic                     row_ok;
	logic [RW-1:0]            in_row;
	logic [FW-1:0]            eff_fill;
	logic                     eff_any;
	logic [RW-1:0]            eff_last;
	logic                     load_ok;
	logic                     opens_row;
	logic [SW-1:0]            q_first;
	logic                     need_fill;
	logic [31:0]              rc32;
	logic [SW-1:0]            n_eff;
	logic [SW-1:0]            half;
	logic [RW-1:0]            row_cur;
	logic                     row_empty;
	logic                     j_last;
	logic                     more_after_k;
	logic                     more_after_start;
	logic                     col_ok;
	logic                     counted;
	logic [LIMIT_W:0]         limit_eff;
	logic                     stop;
	logic signed [ACC_W-1:0]  rhs_ext;
	logic signed [ACC_W:0]    acc_sum;
	logic                     acc_ovf;
	logic signed [ACC_W-1:0]  acc_new;
	logic signed [ACC_W-1:0]  prod_c;
	logic [ACC_W-1:0]         acc_abs;
	logic [DATA_W-1:0]        diag_abs;
	logic                     div_start;
	logic                     div_done;
	logic [ACC_W-1:0]         div_quot;
	logic                     quot_ovf;
	logic signed [DATA_W-1:0] quot_val;
	logic signed [DATA_W:0]   diff;
	logic [DATA_W-1:0]        change;

	sgs_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_abs),
		.divisor  (diag_abs),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk) begin
		if (sol_we) begin
			sol_mem[sol_waddr] <= sol_wdata;
		end
		sol_rd <= sol_mem[sol_raddr];
	end

	always_ff @(posedge clk) begin
		if (rhs_we) begin
			rhs_mem[in_row] <= rhs_value;
		end
		rhs_rd <= rhs_mem[rhs_raddr];
	end

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[EW'(eff_fill)] <= entry_value;
			col_mem[EW'(eff_fill)]  <= col_index;
		end
		coef_rd <= coef_mem[coef_raddr];
		col_rd  <= col_mem[coef_raddr];
	end

	always_ff @(posedge clk) begin
		if (rs_we) begin
			rs_mem[rs_waddr] <= rs_wdata;
		end
		rs_rd <= rs_mem[rs_raddr];
	end

	always_comb begin
		accept    = in_valid && in_ready;
		in_row32  = 32'(row_index);
		row_ok    = (in_row32 < 32'(MAX_ROWS));
		in_row    = RW'(in_row32);
		eff_fill  = open_q ? fill_q : '0;
		eff_any   = open_q && any_q;
		eff_last  = open_q ? last_q : '0;
		load_ok   = row_ok && (32'(eff_fill) < 32'(MAX_NONZEROS));
		opens_row = !eff_any || (in_row > eff_last);
		q_first   = eff_any ? SW'(32'(eff_last) + 32'd1) : '0;
		need_fill = load_ok && opens_row && (SW'(in_row32) != q_first);

		rc32 = 32'(row_count_q);
		if (rc32 < 32'd2) begin
			n_eff = SW'(2);
		end else if (rc32 > 32'(MAX_ROWS)) begin
			n_eff = SW'(MAX_ROWS);
		end else begin
			n_eff = SW'(rc32);
		end
		half = n_q >> 1;

		unique case (phase_q)
			PH_FIRST: row_cur = '0;
			PH_LAST:  row_cur = RW'(32'(n_q) - 32'd1);
			PH_EVEN:  row_cur = RW'({j_q, 1'b0});
			PH_ODD:   row_cur = RW'({j_q, 1'b1});
			default:  row_cur = '0;
		endcase
		row_empty        = !any_q || (row_cur > last_q);
		j_last           = ((32'(j_q) + 32'd1) == 32'(half));
		more_after_k     = ((32'(k_q) + 32'd1) < 32'(end_q));
		more_after_start = ((32'(start_q) + 32'd1) < 32'(end_q));
		col_ok           = (32'(col_rd) < 32'(n_q));
		counted          = (phase_q == PH_EVEN) || (phase_q == PH_ODD)
			|| ((phase_q == PH_LAST) && n_q[0]);
		limit_eff        = (sweep_limit_q == '0) ? (LIMIT_W+1)'(1) : {1'b0, sweep_limit_q};
		stop             = (res_q < {1'b0, tolerance_q})
			|| (({1'b0, it_q} + 1'b1) >= limit_eff);

		rhs_ext = ACC_W'(rhs_rd);
		prod_c  = coef_q * sol_rd;
		acc_sum = (ACC_W+1)'(acc_q) - (ACC_W+1)'(prod_q);
		acc_ovf = (acc_sum[ACC_W] != acc_sum[ACC_W-1]);
		if (acc_ovf) begin
			acc_new = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_new = acc_sum[ACC_W-1:0];
		end
		acc_abs  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : acc_q;
		diag_abs = diag_q[DATA_W-1] ? DATA_W'(-diag_q) : diag_q;

		if (neg_q) begin
			quot_ovf = (div_quot[ACC_W-1:DATA_W] != '0)
				|| (div_quot[DATA_W-1] && (div_quot[DATA_W-2:0] != '0));
			quot_val = quot_ovf ? DATA_MIN : DATA_W'(-div_quot[DATA_W-1:0]);
		end else begin
			quot_ovf = (div_quot[ACC_W-1:DATA_W-1] != '0);
			quot_val = quot_ovf ? DATA_MAX : div_quot[DATA_W-1:0];
		end

		diff   = (DATA_W+1)'(nv_q) - (DATA_W+1)'(old_q);
		change = diff[DATA_W] ? DATA_W'(-diff) : DATA_W'(diff);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd)
						CMD_LOAD_ENTRY:  state_d = need_fill ? S_LOAD_FILL : S_IDLE;
						CMD_LOAD_VECTOR: state_d = S_IDLE;
						CMD_SOLVE:       state_d = S_ROW_A;
						CMD_READ:        state_d = S_READ;
						default:         state_d = S_IDLE;
					endcase
				end
			end
			S_LOAD_FILL: state_d = (fq_q == ftgt_q) ? S_IDLE : S_LOAD_FILL;
			S_READ:      state_d = S_IDLE;
			S_ROW_A:     state_d = S_ROW_B;
			S_ROW_B:     state_d = S_ROW_C;
			S_ROW_C:     state_d = S_ROW_D;
			S_ROW_D:     state_d = more_after_start ? S_ENT_A : S_OLD_A;
			S_ENT_A:     state_d = S_ENT_B;
			S_ENT_B: begin
				if (col_ok) begin
					state_d = S_ENT_C;
				end else begin
					state_d = more_after_k ? S_ENT_A : S_OLD_A;
				end
			end
			S_ENT_C:     state_d = S_ENT_D;
			S_ENT_D:     state_d = more_after_k ? S_ENT_A : S_OLD_A;
			S_OLD_A:     state_d = S_OLD_B;
			S_OLD_B:     state_d = (diag_q == '0) ? S_WB : S_DIV;
			S_DIV:       state_d = div_done ? S_WB : S_DIV;
			S_WB:        state_d = ((phase_q == PH_ODD) && j_last) ? S_SWEEP_END : S_ROW_A;
			S_SWEEP_END: state_d = stop ? S_IDLE : S_ROW_A;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == S_IDLE) && !out_valid_q;
		cfg_ready  = 1'b1;
		sol_we     = 1'b0;
		sol_waddr  = in_row;
		sol_wdata  = guess_value;
		sol_raddr  = '0;
		rhs_we     = 1'b0;
		rhs_raddr  = '0;
		coef_we    = 1'b0;
		coef_raddr = '0;
		rs_we      = 1'b0;
		rs_waddr   = q_first;
		rs_wdata   = eff_fill;
		rs_raddr   = '0;
		div_start  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd)
						CMD_LOAD_ENTRY: begin
							coef_we = load_ok;
							rs_we   = load_ok && opens_row;
						end
						CMD_LOAD_VECTOR: begin
							rhs_we = row_ok;
							sol_we = row_ok;
						end
						CMD_READ:  sol_raddr = in_row;
						CMD_SOLVE: sol_raddr = '0;
						default:   sol_raddr = '0;
					endcase
				end
			end
			S_LOAD_FILL: begin
				rs_we    = 1'b1;
				rs_waddr = fq_q;
				rs_wdata = fval_q;
			end
			S_ROW_A: begin
				rs_raddr  = SW'(32'(row_cur));
				rhs_raddr = row_cur;
			end
			S_ROW_B: rs_raddr = SW'(32'(row_cur) + 32'd1);
			S_ROW_C: coef_raddr = EW'(start_q);
			S_ENT_A: coef_raddr = EW'(k_q);
			S_ENT_B: sol_raddr = RW'(32'(col_rd));
			S_OLD_A: sol_raddr = row_cur;
			S_OLD_B: div_start = (diag_q != '0);
			S_WB: begin
				sol_we    = 1'b1;
				sol_waddr = row_cur;
				sol_wdata = nv_q;
			end
			default: div_start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			row_count_q   <= ROW_COUNT_RST;
			tolerance_q   <= TOLERANCE_RST;
			sweep_limit_q <= SWEEP_LIMIT_RST;
			fill_q        <= '0;
			open_q        <= 1'b0;
			any_q         <= 1'b0;
			last_q        <= '0;
			fault_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_ROW_COUNT) begin
					row_count_q <= cfg_data[ROWCNT_W-1:0];
				end else if (cfg_index == CFG_TOLERANCE) begin
					tolerance_q <= cfg_data;
				end else if (cfg_index == CFG_SWEEP_LIMIT) begin
					sweep_limit_q <= cfg_data[LIMIT_W-1:0];
				end
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && (cmd == CMD_LOAD_ENTRY)) begin
						open_q <= 1'b1;
						fill_q <= eff_fill;
						any_q  <= eff_any;
						last_q <= eff_last;
						if (load_ok) begin
							fill_q <= eff_fill + 1'b1;
							if (opens_row) begin
								any_q  <= 1'b1;
								last_q <= in_row;
							end
						end
					end else if (accept && (cmd == CMD_SOLVE)) begin
						open_q  <= 1'b0;
						fault_q <= 1'b0;
					end
				end
				S_READ:  out_valid_q <= 1'b1;
				S_ENT_D: begin
					if (acc_ovf) begin
						fault_q <= 1'b1;
					end
				end
				S_OLD_B: begin
					if (diag_q == '0) begin
						fault_q <= 1'b1;
					end
				end
				S_DIV: begin
					if (div_done && quot_ovf) begin
						fault_q <= 1'b1;
					end
				end
				S_SWEEP_END: begin
					if (stop) begin
						out_valid_q <= 1'b1;
					end
				end
				default: fault_q <= fault_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				fq_q    <= q_first + 1'b1;
				ftgt_q  <= SW'(in_row32);
				fval_q  <= eff_fill;
				rd_ok_q <= row_ok;
				if (accept && (cmd == CMD_SOLVE)) begin
					n_q     <= n_eff;
					it_q    <= '0;
					res_q   <= '0;
					phase_q <= PH_FIRST;
					j_q     <= '0;
				end
			end
			S_LOAD_FILL: fq_q <= fq_q + 1'b1;
			S_READ: begin
				kind_q   <= 1'b1;
				sweep_q  <= '0;
				resid_q  <= '0;
				solv_q   <= rd_ok_q ? sol_rd : '0;
				ofault_q <= fault_q;
			end
			S_ROW_B: begin
				start_q <= rs_rd;
				acc_q   <= rhs_ext <<< FRAC_BITS;
			end
			S_ROW_C: begin
				if (row_empty) begin
					start_q <= fill_q;
					end_q   <= fill_q;
				end else begin
					end_q <= (row_cur < last_q) ? rs_rd : fill_q;
				end
			end
			S_ROW_D: begin
				diag_q <= (start_q < end_q) ? coef_rd : '0;
				k_q    <= KW'(start_q) + 1'b1;
			end
			S_ENT_B: begin
				coef_q <= coef_rd;
				if (!col_ok) begin
					k_q <= k_q + 1'b1;
				end
			end
			S_ENT_C: prod_q <= prod_c;
			S_ENT_D: begin
				acc_q <= acc_new;
				k_q   <= k_q + 1'b1;
			end
			S_OLD_B: begin
				old_q <= sol_rd;
				neg_q <= acc_q[ACC_W-1] ^ diag_q[DATA_W-1];
				if (diag_q == '0) begin
					nv_q <= acc_q[ACC_W-1] ? DATA_MIN : DATA_MAX;
				end
			end
			S_DIV: begin
				if (div_done) begin
					nv_q <= quot_val;
				end
			end
			S_WB: begin
				if (counted && (change > res_q)) begin
					res_q <= change;
				end
				unique case (phase_q)
					PH_FIRST: phase_q <= PH_LAST;
					PH_LAST: begin
						phase_q <= PH_EVEN;
						j_q     <= '0;
					end
					PH_EVEN: begin
						if (j_last) begin
							phase_q <= PH_ODD;
							j_q     <= '0;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
					PH_ODD: begin
						if (!j_last) begin
							j_q <= j_q + 1'b1;
						end
					end
					default: phase_q <= PH_FIRST;
				endcase
			end
			S_SWEEP_END: begin
				if (stop) begin
					kind_q   <= 1'b0;
					sweep_q  <= it_q;
					resid_q  <= res_q[DATA_W-1] ? RES_MAX : res_q[RES_W-1:0];
					solv_q   <= '0;
					ofault_q <= fault_q;
				end else begin
					it_q    <= it_q + 1'b1;
					res_q   <= '0;
					phase_q <= PH_FIRST;
					j_q     <= '0;
				end
			end
			default: k_q <= k_q;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = kind_q;
	assign sweep_index    = sweep_q;
	assign final_residual = resid_q;
	assign solution_value = solv_q;
	assign divide_fault   = ofault_q;

	a_out_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (state_q == S_IDLE))
		else $error("result word pending outside the idle state");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished while the sequencer was not waiting for it");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= 32'(MAX_NONZEROS))
		else $error("entry fill count beyond the coefficient store");

	a_solve_word_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !kind_q) |-> (solv_q == '0))
		else $error("solve result word carries solution data");

	a_sweep_restart: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SWEEP_END) && !stop) |=> ((state_q == S_ROW_A) && (res_q == '0)))
		else $error("new sweep did not restart with a cleared residual");

endmodule

`default_nettype wire

/* tb/sgs_result_checker.sv */
`default_nettype none

module sgs_result_checker
	import sgs_pkg::*;
#(
	parameter int MAX_ROWS     = 256,
	parameter int MAX_NONZEROS = 2048,
	parameter int FRAC_BITS    = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic                       in_ready,
	input  wire logic [CMD_W-1:0]           cmd,
	input  wire logic [IDX_W-1:0]           row_index,
	input  wire logic [IDX_W-1:0]           col_index,
	input  wire logic signed [DATA_W-1:0]   entry_value,
	input  wire logic signed [DATA_W-1:0]   rhs_value,
	input  wire logic signed [DATA_W-1:0]   guess_value,
	input  wire logic                       out_valid,
	input  wire logic                       out_ready,
	input  wire logic                       result_kind,
	input  wire logic [LIMIT_W-1:0]         sweep_index,
	input  wire logic [RES_W-1:0]           final_residual,
	input  wire logic signed [DATA_W-1:0]   solution_value,
	input  wire logic                       divide_fault,
	input  wire logic                       cfg_valid,
	input  wire logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [RES_W-1:0]           cfg_data,
	output int                              pending,
	output int                              fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                     kind;
		logic [LIMIT_W-1:0]       sweep;
		logic [RES_W-1:0]         residual;
		logic signed [DATA_W-1:0] value;
		logic                     fault;
	} result_word_t;

	result_word_t awaited_words[$];

	logic signed [DATA_W-1:0] x_vec[MAX_ROWS];
	logic signed [DATA_W-1:0] b_vec[MAX_ROWS];
	logic signed [DATA_W-1:0] coef_mem[MAX_NONZEROS];
	logic [IDX_W-1:0]         col_mem[MAX_NONZEROS];
	int unsigned              row_base[MAX_ROWS+1];
	longint unsigned          row_delta[MAX_ROWS];
	int unsigned              fill_level, top_row;
	bit                       fault_seen, matrix_open, any_entry;
	int unsigned              rows_reg, tol_reg, limit_reg;
	int                       mismatches;

	assign fail_count = mismatches;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic longint acc_add(input longint a, input longint b);
		if (b > 0 && a > ACC_MAX - b) begin
			fault_seen = 1;
			return ACC_MAX;
		end
		if (b < 0 && a < ACC_MIN - b) begin
			fault_seen = 1;
			return ACC_MIN;
		end
		return a + b;
	endfunction

	function automatic logic signed [DATA_W-1:0] divide_q(input longint num,
			input logic signed [DATA_W-1:0] den);
		longint unsigned un, ud, q;
		if (den == 0) begin
			fault_seen = 1;
			return (num >= 0) ? DATA_MAX : DATA_MIN;
		end
		un = (num < 0) ? -num : num;
		ud = (den < 0) ? -longint'(den) : longint'(den);
		q = un / ud;
		if ((num < 0) != (den < 0)) begin
			if (q > 64'h8000_0000) begin
				fault_seen = 1;
				return DATA_MIN;
			end
			return DATA_W'(-q);
		end
		if (q > 64'h7FFF_FFFF) begin
			fault_seen = 1;
			return DATA_MAX;
		end
		return q[DATA_W-1:0];
	endfunction

	function automatic void relax_row(input int unsigned r, input int unsigned n);
		int unsigned lo, hi, k;
		longint acc, dlt;
		logic signed [DATA_W-1:0] diag, nv;
		diag = 0;
		if (!any_entry || r > top_row) begin
			lo = fill_level;
			hi = fill_level;
		end else begin
			lo = row_base[r];
			hi = (r < top_row) ? row_base[r+1] : fill_level;
		end
		acc = longint'(b_vec[r]) * (longint'(1) << FRAC_BITS);
		for (k = lo + 1; k < hi && k < MAX_NONZEROS; k++)
			if (col_mem[k] < n)
				acc = acc_add(acc, -(longint'(coef_mem[k]) * longint'(x_vec[col_mem[k]])));
		if (lo < hi && lo < MAX_NONZEROS)
			diag = coef_mem[lo];
		nv = divide_q(acc, diag);
		dlt = longint'(nv) - longint'(x_vec[r]);
		row_delta[r] = (dlt < 0) ? -dlt : dlt;
		x_vec[r] = nv;
	endfunction

	function automatic void load_coefficient(input int unsigned r, input logic [IDX_W-1:0] c,
			input logic signed [DATA_W-1:0] v);
		int unsigned q;
		if (!matrix_open) begin
			matrix_open = 1;
			fill_level = 0;
			any_entry = 0;
			top_row = 0;
		end
		if (r >= MAX_ROWS || fill_level >= MAX_NONZEROS)
			return;
		if (!any_entry) begin
			for (q = 0; q <= r; q++)
				row_base[q] = fill_level;
			top_row = r;
			any_entry = 1;
		end else if (r > top_row) begin
			for (q = top_row + 1; q <= r; q++)
				row_base[q] = fill_level;
			top_row = r;
		end
		coef_mem[fill_level] = v;
		col_mem[fill_level] = c;
		fill_level++;
	endfunction

	function automatic result_word_t solve_system();
		int unsigned n, lim, it, r, half;
		longint unsigned res;
		result_word_t w;
		n = rows_reg;
		lim = (limit_reg != 0) ? limit_reg : 1;
		if (n < 2)
			n = 2;
		if (n > MAX_ROWS)
			n = MAX_ROWS;
		half = n / 2;
		matrix_open = 0;
		fault_seen = 0;
		for (it = 0; ; it++) begin
			relax_row(0, n);
			relax_row(n - 1, n);
			for (r = 0; r < half; r++)
				relax_row(2 * r, n);
			for (r = 0; r < half; r++)
				relax_row(2 * r + 1, n);
			res = 0;
			for (r = 0; r < n; r++)
				if (row_delta[r] > res)
					res = row_delta[r];
			if (res < tol_reg || it + 1 >= lim)
				break;
		end
		if (res > 64'h7FFF_FFFF)
			res = 64'h7FFF_FFFF;
		w.kind = 1'b0;
		w.sweep = it[LIMIT_W-1:0];
		w.residual = res[RES_W-1:0];
		w.value = '0;
		w.fault = fault_seen;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_word_t w, want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_ROWS; i++) begin
				x_vec[i] = 0;
				b_vec[i] = 0;
				row_delta[i] = 0;
			end
			for (int i = 0; i < MAX_NONZEROS; i++) begin
				coef_mem[i] = 0;
				col_mem[i] = 0;
			end
			for (int i = 0; i <= MAX_ROWS; i++)
				row_base[i] = 0;
			fill_level = 0;
			top_row = 0;
			fault_seen = 0;
			matrix_open = 0;
			any_entry = 0;
			rows_reg = ROW_COUNT_RST;
			tol_reg = TOLERANCE_RST;
			limit_reg = SWEEP_LIMIT_RST;
			awaited_words.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ROW_COUNT: rows_reg = cfg_data[ROWCNT_W-1:0];
					CFG_TOLERANCE: tol_reg = cfg_data;
					CFG_SWEEP_LIMIT: limit_reg = cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (awaited_words.size() == 0) begin
					$display("%0t result word arrived with none expected", $realtime);
					mismatches++;
				end else begin
					want = awaited_words.pop_front();
					if (result_kind !== want.kind)
						report_mismatch("result_kind", result_kind, want.kind);
					if (sweep_index !== want.sweep)
						report_mismatch("sweep_index", sweep_index, want.sweep);
					if (final_residual !== want.residual)
						report_mismatch("final_residual", final_residual, want.residual);
					if (solution_value !== want.value)
						report_mismatch("solution_value", solution_value, want.value);
					if (divide_fault !== want.fault)
						report_mismatch("divide_fault", divide_fault, want.fault);
				end
			end
			if (in_valid && in_ready) begin
				case (cmd)
					CMD_LOAD_ENTRY: load_coefficient(row_index, col_index, entry_value);
					CMD_LOAD_VECTOR: begin
						if (row_index < MAX_ROWS) begin
							b_vec[row_index] = rhs_value;
							x_vec[row_index] = guess_value;
						end
					end
					CMD_READ: begin
						w.kind = 1'b1;
						w.sweep = '0;
						w.residual = '0;
						w.value = (row_index < MAX_ROWS) ? x_vec[row_index] : '0;
						w.fault = fault_seen;
						awaited_words.push_back(w);
					end
					default: awaited_words.push_back(solve_system());
				endcase
			end
			pending <= awaited_words.size();
		end
	end

endmodule

`default_nettype wire

/* tb/sparse_gauss_seidel_solver_unit_test.sv */
`default_nettype none

module sparse_gauss_seidel_solver_unit_test;
	import sgs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int QUIET_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CMD_W-1:0] cmd = CMD_LOAD_ENTRY;
	logic [IDX_W-1:0] row_index = '0;
	logic [IDX_W-1:0] col_index = '0;
	logic signed [DATA_W-1:0] entry_value = '0;
	logic signed [DATA_W-1:0] rhs_value = '0;
	logic signed [DATA_W-1:0] guess_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic result_kind;
	logic [LIMIT_W-1:0] sweep_index;
	logic [RES_W-1:0] final_residual;
	logic signed [DATA_W-1:0] solution_value;
	logic divide_fault;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_ROW_COUNT;
	logic [RES_W-1:0] cfg_data = '0;

	int pending, fail_count;
	int tx_idle = 0, rx_idle = 0;
	int hold_seq = 0, hold_seen = 0, hold_left = 0;
	int cycles = 0;
	int words_sent = 0, answers_due = 0;
	int unsigned rows_now = ROW_COUNT_RST;

	always #2 clk = ~clk;

	sparse_gauss_seidel_solver_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .row_index(row_index), .col_index(col_index),
		.entry_value(entry_value), .rhs_value(rhs_value), .guess_value(guess_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_kind(result_kind), .sweep_index(sweep_index),
		.final_residual(final_residual), .solution_value(solution_value),
		.divide_fault(divide_fault),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	sgs_result_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .row_index(row_index), .col_index(col_index),
		.entry_value(entry_value), .rhs_value(rhs_value), .guess_value(guess_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_kind(result_kind), .sweep_index(sweep_index),
		.final_residual(final_residual), .solution_value(solution_value),
		.divide_fault(divide_fault),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.pending(pending), .fail_count(fail_count)
	);

	// The receiver honours a requested hold-off first, otherwise it stalls at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= 3000;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [DATA_W-1:0] small_fx();
		return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
	endfunction

	function automatic logic [DATA_W-1:0] diag_fx();
		logic [DATA_W-1:0] m;
		m = $urandom_range(32'h2_0000, 32'h6_0000);
		return $urandom_range(1) ? m : -m;
	endfunction

	task automatic send_word(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] k, input logic [DATA_W-1:0] e,
			input logic [DATA_W-1:0] h, input logic [DATA_W-1:0] g);
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		row_index <= r;
		col_index <= k;
		entry_value <= e;
		rhs_value <= h;
		guess_value <= g;
		do
			@(posedge clk);
		while (!in_ready);
		if (c == CMD_SOLVE || c == CMD_READ)
			answers_due++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RES_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == CFG_ROW_COUNT)
			rows_now = (d[8:0] < 2) ? 2 : (d[8:0] > 256) ? 256 : d[8:0];
	endtask

	task automatic configure(input logic [RES_W-1:0] rows, input logic [RES_W-1:0] tol,
			input logic [RES_W-1:0] lim);
		settle();
		write_reg(CFG_ROW_COUNT, rows);
		write_reg(CFG_TOLERANCE, tol);
		write_reg(CFG_SWEEP_LIMIT, lim);
	endtask

	task automatic load_system();
		int unsigned r, j, offs;
		for (r = 0; r < rows_now; r++) begin
			if ($urandom_range(9) == 0)
				continue;
			send_word(CMD_LOAD_ENTRY, r, r, ($urandom_range(19) == 0) ? '0 : diag_fx(), '0, '0);
			offs = $urandom_range(2);
			for (j = 0; j < offs; j++)
				send_word(CMD_LOAD_ENTRY, r, $urandom_range(rows_now), small_fx() >>> 1,
					'0, '0);
		end
		for (r = 0; r < rows_now; r++)
			if ($urandom_range(1))
				send_word(CMD_LOAD_VECTOR, r, '0, '0, small_fx(), small_fx());
		send_word(CMD_SOLVE, '0, '0, '0, '0, '0);
		for (j = $urandom_range(1, 3); j > 0; j--)
			send_word(CMD_READ, $urandom_range(rows_now - 1), '0, '0, '0, '0);
	endtask

	initial begin
		int n_random;
		n_random = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every vector element is written up front so that no solve or read sees an unset one.
		for (int r = 0; r < 256; r++)
			send_word(CMD_LOAD_VECTOR, r, '0, '0, small_fx(), small_fx());

		configure(4, 0, 3);
		send_word(CMD_LOAD_ENTRY, 0, 0, 32'h0004_0000, '0, '0);
		send_word(CMD_LOAD_ENTRY, 0, 1, 32'hFFFF_0000, '0, '0);
		send_word(CMD_LOAD_ENTRY, 0, 255, DATA_MAX, '0, '0);
		send_word(CMD_LOAD_ENTRY, 2, 2, DATA_MIN, '0, '0);
		send_word(CMD_LOAD_ENTRY, 2, 3, DATA_MAX, '0, '0);
		send_word(CMD_LOAD_ENTRY, 1, 0, 32'h0001_0000, '0, '0);
		send_word(CMD_LOAD_ENTRY, 3, 3, 32'h0002_0000, '0, '0);
		send_word(CMD_LOAD_ENTRY, 3, 0, 32'h0000_8000, '0, '0);
		send_word(CMD_LOAD_VECTOR, 3, 255, '0, DATA_MAX, DATA_MIN);
		send_word(CMD_LOAD_VECTOR, 0, 0, '0, DATA_MIN, DATA_MAX);
		send_word(CMD_SOLVE, '0, '0, '0, '0, '0);
		for (int r = 0; r < 4; r++)
			send_word(CMD_READ, r, '0, '0, '0, '0);
		send_word(CMD_READ, 255, 255, DATA_MAX, DATA_MAX, DATA_MAX);
		send_word(CMD_SOLVE, '0, '0, '0, '0, '0);
		send_word(CMD_LOAD_ENTRY, 255, 255, 32'h0001_0000, '0, '0);
		send_word(CMD_LOAD_ENTRY, 255, 0, DATA_MIN, '0, '0);
		send_word(CMD_SOLVE, '0, '0, '0, '0, '0);
		send_word(CMD_READ, 255, '0, '0, '0, '0);

		configure(511, 31'h7FFF_FFFF, 1);
		send_word(CMD_SOLVE, '0, '0, '0, '0, '0);
		send_word(CMD_READ, 128, '0, '0, '0, '0);

		configure(2, 0, 255);
		send_word(CMD_LOAD_ENTRY, 0, 0, 32'h0004_0000, '0, '0);
		send_word(CMD_LOAD_ENTRY, 0, 1, 32'h0001_0000, '0, '0);
		send_word(CMD_LOAD_ENTRY, 1, 1, 32'h0004_0000, '0, '0);
		send_word(CMD_SOLVE, '0, '0, '0, '0, '0);

		// Overfill the coefficient store; the surplus entries must be dropped.
		configure(0, 66, 0);
		send_word(CMD_LOAD_ENTRY, 0, 0, 32'h0004_0000, '0, '0);
		send_word(CMD_LOAD_ENTRY, 1, 1, 32'h0004_0000, '0, '0);
		for (int i = 0; i < 2060; i++)
			send_word(CMD_LOAD_ENTRY, $urandom_range(1), $urandom_range(3), small_fx() >>> 8,
				'0, '0);
		send_word(CMD_SOLVE, '0, '0, '0, '0, '0);
		send_word(CMD_READ, 1, '0, '0, '0, '0);

		answers_due = 0;
		while (n_random < 400 || answers_due < 48) begin
			if (n_random < 140) begin
				tx_idle = 35;
				rx_idle = 79;
			end else if (n_random < 280) begin
				tx_idle = 79;
				rx_idle = 35;
			end else begin
				tx_idle = 0;
				rx_idle = 0;
			end
			if ($urandom_range(3) == 0) begin
				if ($urandom_range(9) == 0)
					configure($urandom_range(2, 40), $urandom, 1);
				else
					configure($urandom_range(2, 6),
						$urandom_range(1) ? $urandom_range(0, 2000) : $urandom,
						$urandom_range(1, 4));
			end
			if (hold_seq == 0 && n_random >= 200) begin
				settle();
				hold_seq = 1;
				for (int j = 0; j < 8; j++)
					send_word(CMD_READ, $urandom_range(255), '0, '0, '0, '0);
				n_random += 8;
			end
			if ($urandom_range(4) != 0) begin
				int before_words;
				before_words = words_sent;
				load_system();
				n_random += 3 * rows_now;
			end else begin
				for (int j = $urandom_range(1, 6); j > 0; j--) begin
					send_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
					n_random++;
				end
			end
		end

		settle();
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
